[design/uks_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uks_pkg
// Shared types and constants for the unique key set with sorted dump.
// ----------------------------------------------------------------------------
package uks_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int CMD_W        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_APPLY,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic lookup;
        logic apply;
        logic scan;
        logic emit;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic scan_done;
        logic dump_last;
    } sts_t;

endpackage

[design/uks_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uks_ctrl
// Sequencer for lookup/update and the repeated minimum-search passes of dump.
// ----------------------------------------------------------------------------
module uks_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [uks_pkg::CMD_W-1:0]   cmd,
    output uks_pkg::ctl_t               ctl,
    input  uks_pkg::sts_t               sts
);
    import uks_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd_t'(cmd) == CMD_DUMP) ? ST_SCAN : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.dump_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        ctl         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctl.capture = in_valid;
            end
            ST_LOOKUP:
            begin
                ctl.lookup = 1'b1;
            end
            ST_APPLY:
            begin
                ctl.apply = sts.out_free;
            end
            ST_SCAN:
            begin
                ctl.scan = 1'b1;
            end
            ST_EMIT:
            begin
                ctl.emit = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[design/uks_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uks_dpath
// Slot storage, parallel key match, scan unit for dump and result register.
// ----------------------------------------------------------------------------
module uks_dpath
#(
    parameter int CAPACITY = uks_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [uks_pkg::CMD_W-1:0]           cmd,
    input  logic signed [uks_pkg::KEY_W-1:0]    key,
    input  uks_pkg::ctl_t                       ctl,
    output uks_pkg::sts_t                       sts,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                ok,
    output logic signed [uks_pkg::KEY_W-1:0]    item_key,
    output logic                                is_empty,
    output logic                                last
);
    import uks_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // storage
    logic signed [KEY_W-1:0] slot_key_reg [CAPACITY];
    logic [CAPACITY-1:0]     slot_valid_reg;
    logic [CAPACITY-1:0]     slot_valid_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;

    // current item
    cmd_t                    cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CAPACITY-1:0]     match_reg;

    // dump scan
    logic [IDX_W-1:0]        scan_idx_reg;
    logic [IDX_W-1:0]        scan_idx_next;
    logic                    found_reg;
    logic                    found_next;
    logic                    have_prev_reg;
    logic                    have_prev_next;
    logic [CNT_W-1:0]        emitted_reg;
    logic [CNT_W-1:0]        emitted_next;
    logic signed [KEY_W-1:0] best_reg;
    logic signed [KEY_W-1:0] prev_reg;

    // result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    ok_reg;
    logic signed [KEY_W-1:0] item_key_reg;
    logic                    is_empty_reg;
    logic                    last_reg;

    logic [CAPACITY-1:0]     match_vec;
    logic [CAPACITY-1:0]     free_oh;
    logic                    hit;
    logic                    full;
    logic                    res_ok;
    logic                    ins_done;
    logic                    del_done;
    logic signed [KEY_W-1:0] cur_key;
    logic                    cur_valid;
    logic                    take;
    logic                    out_load;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_vec[i] = slot_valid_reg[i] && (slot_key_reg[i] == key_reg);
        end
    end

    // lowest clear bit as one-hot
    assign free_oh = ~slot_valid_reg & (slot_valid_reg + {{(CAPACITY-1){1'b0}}, 1'b1});
    assign hit     = |match_reg;
    assign full    = &slot_valid_reg;

    always_comb
    begin
        case (cmd_reg)
            CMD_INSERT: res_ok = !hit && !full;
            CMD_DELETE: res_ok = hit;
            CMD_SEARCH: res_ok = hit;
            default:    res_ok = hit;
        endcase
    end

    assign ins_done = ctl.apply && (cmd_reg == CMD_INSERT) && res_ok;
    assign del_done = ctl.apply && (cmd_reg == CMD_DELETE) && res_ok;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        cnt_next        = cnt_reg;
        if (ins_done)
        begin
            slot_valid_next = slot_valid_reg | free_oh;
            cnt_next        = cnt_reg + CNT_W'(1);
        end
        else if (del_done)
        begin
            slot_valid_next = slot_valid_reg & ~match_reg;
            cnt_next        = cnt_reg - CNT_W'(1);
        end
    end

    // one slot per scan cycle: smallest key above the one emitted last
    assign cur_key   = slot_key_reg[scan_idx_reg];
    assign cur_valid = slot_valid_reg[scan_idx_reg];
    assign take      = cur_valid && (!have_prev_reg || (cur_key > prev_reg))
                                 && (!found_reg || (cur_key < best_reg));

    assign sts.scan_done = (scan_idx_reg == IDX_W'(CAPACITY - 1));
    assign sts.dump_last = !found_reg || ((emitted_reg + CNT_W'(1)) == cnt_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        have_prev_next = have_prev_reg;
        emitted_next   = emitted_reg;
        if (ctl.capture)
        begin
            scan_idx_next  = '0;
            found_next     = 1'b0;
            have_prev_next = 1'b0;
            emitted_next   = '0;
        end
        else if (ctl.scan)
        begin
            scan_idx_next = sts.scan_done ? '0 : scan_idx_reg + IDX_W'(1);
            if (take)
            begin
                found_next = 1'b1;
            end
        end
        else if (ctl.emit)
        begin
            found_next     = 1'b0;
            have_prev_next = 1'b1;
            emitted_next   = emitted_reg + CNT_W'(1);
        end
    end

    assign out_load = ctl.apply || ctl.emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            cnt_reg        <= '0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            have_prev_reg  <= 1'b0;
            emitted_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            cnt_reg        <= cnt_next;
            scan_idx_reg   <= scan_idx_next;
            found_reg      <= found_next;
            have_prev_reg  <= have_prev_next;
            emitted_reg    <= emitted_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd_t'(cmd);
            key_reg <= key;
        end
        if (ctl.lookup)
        begin
            match_reg <= match_vec;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (ins_done && free_oh[i])
            begin
                slot_key_reg[i] <= key_reg;
            end
        end
        if (ctl.scan && take)
        begin
            best_reg <= cur_key;
        end
        if (ctl.emit)
        begin
            prev_reg <= best_reg;
        end
        if (ctl.apply)
        begin
            ok_reg       <= res_ok;
            item_key_reg <= key_reg;
            is_empty_reg <= 1'b0;
            last_reg     <= 1'b1;
        end
        else if (ctl.emit)
        begin
            ok_reg       <= found_reg;
            item_key_reg <= found_reg ? best_reg : '0;
            is_empty_reg <= !found_reg;
            last_reg     <= sts.dump_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign item_key  = item_key_reg;
    assign is_empty  = is_empty_reg;
    assign last      = last_reg;

endmodule

[design/unique_key_set_with_sorted_dump.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_set_with_sorted_dump
// Set of distinct signed keys with insert, delete, search and sorted dump.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_stall  | cmd, key
//  out     | out_valid / out_stall| ok, item_key, is_empty, last
//
//  insert, delete, search: one beat out, registered through the lookup and apply states
//  dump: each key takes one pass over all slots, one slot compared at a time;
//  an empty set gives a single beat with is_empty set
//  one item at a time; the next input beat is taken while a result waits
//  out_stall holds the result register and delays the next emit
//  reset empties the set at once, no clearing pass
// ----------------------------------------------------------------------------
module unique_key_set_with_sorted_dump
#(
    parameter int CAPACITY = uks_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [uks_pkg::CMD_W-1:0]           cmd,
    input  logic signed [uks_pkg::KEY_W-1:0]    key,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                ok,
    output logic signed [uks_pkg::KEY_W-1:0]    item_key,
    output logic                                is_empty,
    output logic                                last
);
    import uks_pkg::*;

    ctl_t ctl;
    sts_t sts;

    uks_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .ctl      (ctl),
        .sts      (sts)
    );

    uks_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .key       (key),
        .ctl       (ctl),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .item_key  (item_key),
        .is_empty  (is_empty),
        .last      (last)
    );

endmodule

[design/uks_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uks_checker
// Port-level checks for the unique key set, bound to the top level.
// ----------------------------------------------------------------------------
module uks_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                ok,
    input  logic signed [uks_pkg::KEY_W-1:0]    item_key,
    input  logic                                is_empty,
    input  logic                                last
);
    import uks_pkg::*;

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> last && !ok && (item_key == '0))
        else $error("empty dump beat malformed");

    // only dump entries can be non-final, and they always report ok
    a_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> ok && !is_empty)
        else $error("non-final beat is not a dump entry");

endmodule

bind unique_key_set_with_sorted_dump uks_checker u_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends insert, delete, search and dump commands to the unique key set and
// checks every result beat, field by field, against a behavioral set model or
// a typed row's beat. A typed table of directed rows comes first, then random
// traffic in fill, drain and mixed phases, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import uks_pkg::*;

    localparam int SLOTS       = CAPACITY_DEF;
    localparam int N_RANDOM    = 296;
    localparam int CALM_ITEMS  = 40;
    localparam int HOLD_AT     = 90;
    localparam int HOLD_CYCLES = 300;
    localparam int PAUSE_AT    = 180;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 4 * (SLOTS + 2);
    localparam int MAX_PRINTS  = 40;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                    ok;
        logic signed [KEY_W-1:0] item_key;
        logic                    is_empty;
        logic                    last;
    } beat_t;

    typedef struct {
        cmd_t                    op;
        logic signed [KEY_W-1:0] k;
        bit                      typed;
        beat_t                   want;
    } row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        cmd       = CMD_INSERT;
    logic signed [KEY_W-1:0] key       = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    ok;
    logic signed [KEY_W-1:0] item_key;
    logic                    is_empty;
    logic                    last;

    // model of the set
    logic signed [KEY_W-1:0] set_keys [SLOTS];
    bit                      set_used [SLOTS];
    beat_t                   step_beats [$];
    beat_t                   pending_beats [$];
    row_t                    directed [$];

    int  errors        = 0;
    int  items_in      = 0;
    int  total_items   = 1000000;
    int  beats_seen    = 0;
    int  dumps_done    = 0;
    int  full_refusals = 0;
    int  cycles        = 0;
    bit  hold_done     = 1'b0;

    unique_key_set_with_sorted_dump #(.CAPACITY(SLOTS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .item_key  (item_key),
        .is_empty  (is_empty),
        .last      (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int find_key(input logic signed [KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (set_used[i] && set_keys[i] == k)
                return i;
        end
        return -1;
    endfunction

    // applies one command to the model set and leaves its beats in step_beats
    function automatic void set_step(input cmd_t op, input logic signed [KEY_W-1:0] k);
        int                      pos;
        int                      n;
        int                      j;
        logic signed [KEY_W-1:0] v;
        logic signed [KEY_W-1:0] sorted [SLOTS];
        beat_t                   b;
        step_beats.delete();
        pos = find_key(k);
        b   = '{ok: 1'b0, item_key: k, is_empty: 1'b0, last: 1'b1};
        case (op)
            CMD_INSERT:
            begin
                if (pos < 0)
                begin
                    // lowest free slot takes the key
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!set_used[i] && !b.ok)
                        begin
                            set_used[i] = 1'b1;
                            set_keys[i] = k;
                            b.ok        = 1'b1;
                        end
                    end
                    if (!b.ok)
                        full_refusals++;
                end
                step_beats.push_back(b);
            end
            CMD_DELETE:
            begin
                if (pos >= 0)
                begin
                    set_used[pos] = 1'b0;
                    b.ok          = 1'b1;
                end
                step_beats.push_back(b);
            end
            CMD_SEARCH:
            begin
                b.ok = (pos >= 0);
                step_beats.push_back(b);
            end
            default:
            begin
                dumps_done++;
                n = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (set_used[i])
                    begin
                        v = set_keys[i];
                        j = n;
                        while (j > 0 && v < sorted[j-1])
                        begin
                            sorted[j] = sorted[j-1];
                            j--;
                        end
                        sorted[j] = v;
                        n++;
                    end
                end
                if (n == 0)
                    step_beats.push_back('{ok: 1'b0, item_key: '0, is_empty: 1'b1, last: 1'b1});
                else
                    for (int i = 0; i < n; i++)
                        step_beats.push_back('{ok: 1'b1, item_key: sorted[i], is_empty: 1'b0,
                                               last: (i == n - 1)});
            end
        endcase
    endfunction

    function automatic row_t fixed_row(input cmd_t op, input logic signed [KEY_W-1:0] k,
                                       input logic okv);
        row_t r;
        r.op    = op;
        r.k     = k;
        r.typed = 1'b1;
        r.want  = '{ok: okv, item_key: k, is_empty: 1'b0, last: 1'b1};
        return r;
    endfunction

    function automatic row_t free_row(input cmd_t op, input logic signed [KEY_W-1:0] k);
        row_t r;
        r.op    = op;
        r.k     = k;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // key for a random command: often one that is stored, else extremes,
    // small values or anything at all
    function automatic logic signed [KEY_W-1:0] pick_key(input int hit_pct);
        int                      live [$];
        logic signed [KEY_W-1:0] k;
        foreach (set_used[i])
            if (set_used[i])
                live.push_back(i);
        if (live.size() > 0 && $urandom_range(0, 99) < hit_pct)
            return set_keys[live[$urandom_range(0, live.size() - 1)]];
        case ($urandom_range(0, 9))
            0:       k = ($urandom_range(0, 1) != 0) ? KEY_MIN : KEY_MAX;
            1:       k = ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
            2, 3, 4: k = $signed($urandom_range(0, 15)) - 8;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        if (errors < MAX_PRINTS)
            $display("mismatch on %s at beat %0d: got %h, want %h", what, beats_seen, got, want);
        errors++;
    endtask

    task automatic send_item(input cmd_t op, input logic signed [KEY_W-1:0] k,
                             input bit typed, input beat_t want);
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_in <= items_in + 1;
        set_step(op, k);
        if (typed)
            pending_beats.push_back(want);
        else
            foreach (step_beats[i])
                pending_beats.push_back(step_beats[i]);
    endtask

    task automatic sender_gap(input bit calm);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // stimulus
    initial
    begin : command_side
        logic signed [KEY_W-1:0] fill_keys [15];
        int                      mode;
        int                      r;
        cmd_t                    op;
        logic signed [KEY_W-1:0] k;
        fill_keys = '{-32'sd1, 32'sd0, 32'sd1, 32'sd2, -32'sd2, 32'sh5555_5555,
                      32'shaaaa_aaaa, 32'sh7fff_fffe, 32'sh8000_0001, 32'sh0000_ffff,
                      32'shffff_0000, 32'sh1234_5678, 32'shedcb_a987, 32'sh4000_0000,
                      32'shc000_0000};
        mode = 0;

        directed.push_back('{op: CMD_DUMP, k: 32'sh1234_abcd, typed: 1'b1,
                             want: '{ok: 1'b0, item_key: '0, is_empty: 1'b1, last: 1'b1}});
        directed.push_back(fixed_row(CMD_SEARCH, 32'sd0, 1'b0));
        directed.push_back(fixed_row(CMD_DELETE, KEY_MIN, 1'b0));
        directed.push_back(fixed_row(CMD_INSERT, KEY_MIN, 1'b1));
        directed.push_back(fixed_row(CMD_INSERT, KEY_MAX, 1'b1));
        directed.push_back(fixed_row(CMD_INSERT, KEY_MAX, 1'b0));
        directed.push_back(fixed_row(CMD_SEARCH, KEY_MIN, 1'b1));
        directed.push_back(fixed_row(CMD_DELETE, KEY_MIN, 1'b1));
        directed.push_back(fixed_row(CMD_DELETE, KEY_MIN, 1'b0));
        foreach (fill_keys[i])
            directed.push_back(free_row(CMD_INSERT, fill_keys[i]));
        // set is full now
        directed.push_back(fixed_row(CMD_INSERT, 32'sd3, 1'b0));
        directed.push_back(free_row(CMD_DUMP, KEY_MAX));
        total_items = directed.size() + N_RANDOM;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            sender_gap(1'b0);
            send_item(directed[i].op, directed[i].k, directed[i].typed, directed[i].want);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 40 == 0)
                mode = $urandom_range(0, 2);
            sender_gap(directed.size() + n >= total_items - CALM_ITEMS);
            if (n == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_beats.size() != 0)
                    @(posedge clk);
            end
            r = $urandom_range(0, 99);
            case (mode)
                0:       op = (r < 65) ? CMD_INSERT : (r < 75) ? CMD_DELETE :
                              (r < 90) ? CMD_SEARCH : CMD_DUMP;
                1:       op = (r < 15) ? CMD_INSERT : (r < 65) ? CMD_DELETE :
                              (r < 85) ? CMD_SEARCH : CMD_DUMP;
                default: op = (r < 35) ? CMD_INSERT : (r < 60) ? CMD_DELETE :
                              (r < 88) ? CMD_SEARCH : CMD_DUMP;
            endcase
            case (op)
                CMD_INSERT: k = pick_key(20);
                CMD_DELETE: k = pick_key(75);
                CMD_SEARCH: k = pick_key(50);
                default:    k = $urandom;
            endcase
            send_item(op, k, 1'b0, '0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands, %0d dumps, %0d inserts refused on a full set",
                 total_items, dumps_done, full_refusals);
        $display("checked %0d result beats, %0d mismatches", beats_seen, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result side stalls: one long hold-off, random bursts, calm at the end
    initial
    begin : result_side
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && items_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (items_in < total_items - CALM_ITEMS && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_beats.size() == 0)
                report_mismatch("beat with nothing expected", item_key, '0);
            else
            begin
                want = pending_beats.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", KEY_W'(ok), KEY_W'(want.ok));
                if (item_key !== want.item_key)
                    report_mismatch("item_key", item_key, want.item_key);
                if (is_empty !== want.is_empty)
                    report_mismatch("is_empty", KEY_W'(is_empty), KEY_W'(want.is_empty));
                if (last !== want.last)
                    report_mismatch("last", KEY_W'(last), KEY_W'(want.last));
            end
            beats_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d beats outstanding",
                     cycles, pending_beats.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
